// ===== sv/cpmu_pkg.sv =====
// Shared types, constants and the acceptance table for the coupled Potts update.
// No dependencies; imported by cpmu_front, cpmu_back and the top level.
package cpmu_pkg;

    localparam int LATTICE_SIDE = 64;
    localparam int SPIN_STATES = 3;
    localparam int ACCEPT_TABLE_DEPTH = 256;
    localparam int COORD_W = $clog2(LATTICE_SIDE);
    localparam int SITE_COUNT = LATTICE_SIDE * LATTICE_SIDE;
    localparam int ADDR_W = 2 * COORD_W;
    localparam int SPIN_W = 2;
    localparam int DRAW_W = 16;
    localparam int CFG_W = 16;
    localparam int REG_IDX_W = 2;
    localparam int TABLE_IDX_W = $clog2(ACCEPT_TABLE_DEPTH);
    localparam int ENERGY_W = 18;
    localparam int PROD_W = ENERGY_W + CFG_W + 1;
    localparam int IDX_LSB = 18;
    localparam logic [63:0] DECAY_Q32 = 64'd4034748382;

    localparam logic OP_STEP = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_BETA = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FIELD = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COUPLING = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SITE,
        ST_NB1,
        ST_NB2,
        ST_NB3,
        ST_ENERGY,
        ST_MUL,
        ST_DECIDE
    } back_state_t;

    typedef struct packed {
        logic               op;
        logic               layer;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [SPIN_W-1:0]  spin;
        logic [DRAW_W-1:0]  draw;
        logic               spin_ok;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_head_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_status_t;

    typedef logic [DRAW_W-1:0] accept_table_t [ACCEPT_TABLE_DEPTH];

    function automatic accept_table_t build_accept_table();
        accept_table_t tbl;
        logic [63:0]   acc;
        acc = 64'd65535 << 16;
        for (int k = 0; k < ACCEPT_TABLE_DEPTH; k++)
        begin
            tbl[k] = DRAW_W'((acc + 64'h8000) >> 16);
            acc = (acc * DECAY_Q32 + 64'h8000_0000) >> 32;
        end
        return tbl;
    endfunction

    localparam accept_table_t ACCEPT_TABLE = build_accept_table();

endpackage

// ===== sv/cpmu_front.sv =====
// Front part: accepts items, classifies the spin and holds a two-entry queue.
// Depends on cpmu_pkg.
module cpmu_front
    import cpmu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               operation,
    input  logic               layer,
    input  logic [COORD_W-1:0] row,
    input  logic [COORD_W-1:0] column,
    input  logic [SPIN_W-1:0]  proposed_spin,
    input  logic [DRAW_W-1:0]  uniform_draw,
    input  back_status_t       status,
    output cmd_head_t          head
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;
    cmd_t       item;

    assign full    = (count_reg == 2'd2) || status.clearing;
    assign do_push = push && !full;
    assign do_pop  = status.pop && (count_reg != 2'd0);

    always_comb
    begin
        item.op      = operation;
        item.layer   = layer;
        item.row     = row;
        item.col     = column;
        item.spin    = proposed_spin;
        item.draw    = uniform_draw;
        item.spin_ok = (proposed_spin < SPIN_W'(SPIN_STATES));
    end

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = slot_reg[rd_ptr_reg];

endmodule

// ===== sv/cpmu_back.sv =====
// Back part: lattice memories, energy and acceptance sequencer, result register.
// Depends on cpmu_pkg; fed by cpmu_front.
module cpmu_back
    import cpmu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_head_t            head,
    output back_status_t         status,
    input  logic                 write_enable,
    input  logic [REG_IDX_W-1:0] register_index,
    input  logic [CFG_W-1:0]     write_data,
    input  logic                 pop,
    output logic                 empty,
    output logic                 accepted,
    output logic [SPIN_W-1:0]    site_spin
);

    logic [SPIN_W-1:0] mem0 [SITE_COUNT];
    logic [SPIN_W-1:0] mem1 [SITE_COUNT];
    logic [SPIN_W-1:0] rd0_reg, rd1_reg;

    back_state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    cmd_t item_reg, item_next;
    logic [SPIN_W-1:0] ov_reg, ov_next;
    logic [SPIN_W-1:0] xv_reg, xv_next;
    logic [SPIN_W-1:0] nb0_reg, nb0_next;
    logic [SPIN_W-1:0] nb1_reg, nb1_next;
    logic [SPIN_W-1:0] nb2_reg, nb2_next;
    logic signed [ENERGY_W-1:0] de_reg, de_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic out_valid_reg, out_valid_next;
    logic acc_reg, acc_next;
    logic [SPIN_W-1:0] spin_reg, spin_next;
    logic [CFG_W-1:0] beta_reg, field_reg, coupling_reg;

    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic [SPIN_W-1:0] wdata;
    logic we0, we1, we_lat;
    logic [SPIN_W-1:0] lat_rd, oth_rd;
    logic [ADDR_W-1:0] site;
    logic [COORD_W-1:0] r_p, r_m, c_p, c_m;
    logic [2:0] old_m, new_m;
    logic [3:0] dn;
    logic signed [ENERGY_W-1:0] de_base, field_x, coup_x;
    logic [TABLE_IDX_W-1:0] tidx;
    logic take;

    assign site   = {item_reg.row, item_reg.col};
    assign r_p    = item_reg.row + COORD_W'(1);
    assign r_m    = item_reg.row - COORD_W'(1);
    assign c_p    = item_reg.col + COORD_W'(1);
    assign c_m    = item_reg.col - COORD_W'(1);
    assign lat_rd = item_reg.layer ? rd1_reg : rd0_reg;
    assign oth_rd = item_reg.layer ? rd0_reg : rd1_reg;

    assign field_x = ENERGY_W'($signed(field_reg));
    assign coup_x  = ENERGY_W'($signed(coupling_reg));

    always_comb
    begin
        old_m = 3'(ov_reg == nb0_reg) + 3'(ov_reg == nb1_reg)
              + 3'(ov_reg == nb2_reg) + 3'(ov_reg == lat_rd);
        new_m = 3'(item_reg.spin == nb0_reg) + 3'(item_reg.spin == nb1_reg)
              + 3'(item_reg.spin == nb2_reg) + 3'(item_reg.spin == lat_rd);
        dn = 4'(old_m) - 4'(new_m);
        de_base = {{4{dn[3]}}, dn, 10'b0};
    end

    always_comb
    begin
        if (prod_reg[PROD_W-2:IDX_LSB+TABLE_IDX_W] != '0)
        begin
            tidx = '1;
        end
        else
        begin
            tidx = prod_reg[IDX_LSB+TABLE_IDX_W-1:IDX_LSB];
        end
        take = prod_reg[PROD_W-1] || (item_reg.draw < ACCEPT_TABLE[tidx]);
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        item_next      = item_reg;
        ov_next        = ov_reg;
        xv_next        = xv_reg;
        nb0_next       = nb0_reg;
        nb1_next       = nb1_reg;
        nb2_next       = nb2_reg;
        de_next        = de_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !pop;
        acc_next       = acc_reg;
        spin_next      = spin_reg;
        raddr          = site;
        waddr          = site;
        wdata          = item_reg.spin;
        we_lat         = 1'b0;
        we0            = 1'b0;
        we1            = 1'b0;
        status.pop      = 1'b0;
        status.clearing = (state_reg == ST_CLEAR);

        unique case (state_reg)
            ST_CLEAR:
            begin
                waddr    = clr_reg;
                wdata    = '0;
                we0      = 1'b1;
                we1      = 1'b1;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                raddr = {head.cmd.row, head.cmd.col};
                if (head.valid && !out_valid_reg)
                begin
                    status.pop = 1'b1;
                    item_next  = head.cmd;
                    state_next = ST_SITE;
                end
            end
            ST_SITE:
            begin
                raddr = {item_reg.row, c_p};
                if (!item_reg.spin_ok)
                begin
                    out_valid_next = 1'b1;
                    acc_next       = 1'b0;
                    spin_next      = lat_rd;
                    state_next     = ST_IDLE;
                end
                else if (item_reg.op == OP_WRITE)
                begin
                    we_lat         = 1'b1;
                    out_valid_next = 1'b1;
                    acc_next       = 1'b1;
                    spin_next      = item_reg.spin;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    ov_next    = lat_rd;
                    xv_next    = oth_rd;
                    state_next = ST_NB1;
                end
            end
            ST_NB1:
            begin
                raddr      = {item_reg.row, c_m};
                nb0_next   = lat_rd;
                state_next = ST_NB2;
            end
            ST_NB2:
            begin
                raddr      = {r_p, item_reg.col};
                nb1_next   = lat_rd;
                state_next = ST_NB3;
            end
            ST_NB3:
            begin
                raddr      = {r_m, item_reg.col};
                nb2_next   = lat_rd;
                state_next = ST_ENERGY;
            end
            ST_ENERGY:
            begin
                de_next = de_base;
                if ((item_reg.spin == '0) && (ov_reg != '0))
                begin
                    de_next = de_next - field_x;
                end
                else if ((item_reg.spin != '0) && (ov_reg == '0))
                begin
                    de_next = de_next + field_x;
                end
                if ((item_reg.spin == xv_reg) && (ov_reg != xv_reg))
                begin
                    de_next = de_next - coup_x;
                end
                else if ((item_reg.spin != xv_reg) && (ov_reg == xv_reg))
                begin
                    de_next = de_next + coup_x;
                end
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(de_reg * $signed({1'b0, beta_reg}));
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                we_lat         = take;
                out_valid_next = 1'b1;
                acc_next       = take;
                spin_next      = take ? item_reg.spin : ov_reg;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (we_lat)
        begin
            we0 = !item_reg.layer;
            we1 = item_reg.layer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            beta_reg      <= CFG_W'(4096);
            field_reg     <= '0;
            coupling_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (write_enable)
            begin
                unique case (register_index)
                    REG_BETA:     beta_reg     <= write_data;
                    REG_FIELD:    field_reg    <= write_data;
                    REG_COUPLING: coupling_reg <= write_data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        ov_reg   <= ov_next;
        xv_reg   <= xv_next;
        nb0_reg  <= nb0_next;
        nb1_reg  <= nb1_next;
        nb2_reg  <= nb2_next;
        de_reg   <= de_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        spin_reg <= spin_next;
    end

    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            mem0[waddr] <= wdata;
        end
        rd0_reg <= mem0[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we1)
        begin
            mem1[waddr] <= wdata;
        end
        rd1_reg <= mem1[raddr];
    end

    assign empty     = !out_valid_reg;
    assign accepted  = acc_reg;
    assign site_spin = spin_reg;

endmodule

// ===== sv/coupled_potts_metropolis_update.sv =====
// Top level of the coupled three-state Potts Metropolis update.
// A step item runs from queue head through SITE, NB1, NB2, NB3, ENERGY, MUL and DECIDE to the
// result, a write or invalid item through SITE alone. The back part takes no new item until the
// last is done and its result popped; the read port walks five sites for each step item.
// Reset: both lattices are cleared by a pass over all 4096 sites; full stays high until it ends.
// Registers reset to beta 4096, field 0, coupling 0. Depends on cpmu_pkg, cpmu_front, cpmu_back.
module coupled_potts_metropolis_update
    import cpmu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 operation,
    input  logic                 layer,
    input  logic [COORD_W-1:0]   row,
    input  logic [COORD_W-1:0]   column,
    input  logic [SPIN_W-1:0]    proposed_spin,
    input  logic [DRAW_W-1:0]    uniform_draw,
    input  logic                 write_enable,
    input  logic [REG_IDX_W-1:0] register_index,
    input  logic [CFG_W-1:0]     write_data,
    input  logic                 pop,
    output logic                 empty,
    output logic                 accepted,
    output logic [SPIN_W-1:0]    site_spin
);

    cmd_head_t    head;
    back_status_t status;

    cpmu_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .layer         (layer),
        .row           (row),
        .column        (column),
        .proposed_spin (proposed_spin),
        .uniform_draw  (uniform_draw),
        .status        (status),
        .head          (head)
    );

    cpmu_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .status         (status),
        .write_enable   (write_enable),
        .register_index (register_index),
        .write_data     (write_data),
        .pop            (pop),
        .empty          (empty),
        .accepted       (accepted),
        .site_spin      (site_spin)
    );

endmodule
